// ===== design/ats_pkg.sv =====
package ats_pkg;

  localparam int ANGLE_W    = 16;
  localparam int THRESH_W   = 15;
  localparam int ATAN_IDX_W = 5;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd205;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q12 = 16'sd6434;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ANGLE,
    S_COMPARE,
    S_EMIT_BREAK,
    S_RESTART,
    S_REANGLE,
    S_EMIT_FINAL
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_first;
    logic angle_go;
    logic set_ref;
    logic set_prev;
    logic emit_break;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic angle_done;
    logic brk;
    logic out_free;
  } stat_t;

  // Arctangent of 2^-i in Q3.12, rounded to nearest.
  function automatic logic signed [ANGLE_W-1:0] atan_q12(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANGLE_W-1:0] val;
    case (idx)
      5'd0:    val = 16'sd3217;
      5'd1:    val = 16'sd1899;
      5'd2:    val = 16'sd1003;
      5'd3:    val = 16'sd509;
      5'd4:    val = 16'sd256;
      5'd5:    val = 16'sd128;
      5'd6:    val = 16'sd64;
      5'd7:    val = 16'sd32;
      5'd8:    val = 16'sd16;
      5'd9:    val = 16'sd8;
      5'd10:   val = 16'sd4;
      5'd11:   val = 16'sd2;
      5'd12:   val = 16'sd1;
      default: val = 16'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== design/ats_point_if.sv =====
interface ats_point_if #(parameter int CW = 16) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic                 last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

// ===== design/ats_seg_if.sv =====
interface ats_seg_if #(parameter int CW = 16) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] seg_start_x;
  logic signed [CW-1:0] seg_start_y;
  logic signed [CW-1:0] seg_end_x;
  logic signed [CW-1:0] seg_end_y;
  logic                 final_segment;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, final_segment,
                  input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, final_segment,
                output ready);
endinterface

// ===== design/ats_cordic.sv =====
module ats_cordic #(
  parameter int CW = 16,
  parameter int N  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic signed [CW:0]                dx,
  input  logic signed [CW:0]                dy,
  output logic                              done,
  output logic signed [ats_pkg::ANGLE_W-1:0] angle
);
  import ats_pkg::*;

  localparam int PW = CW + 2;
  localparam int W  = PW + N + 2;
  localparam int IW = $clog2(N);

  logic signed [PW-1:0]      ex, ey, px, py;
  logic signed [ANGLE_W-1:0] pz;
  logic signed [W-1:0]       x, y, tx, ty;
  logic signed [ANGLE_W-1:0] z, tab;
  logic [IW-1:0]             iter;
  logic                      busy;
  logic                      is_zero;

  // Pre-rotation into the right half plane.
  always_comb begin
    ex = PW'(dx);
    ey = PW'(dy);
    if (dx < 0 && dy >= 0) begin
      px = ey;
      py = -ex;
      pz = HALF_PI_Q12;
    end else if (dx < 0) begin
      px = -ey;
      py = ex;
      pz = -HALF_PI_Q12;
    end else begin
      px = ex;
      py = ey;
      pz = '0;
    end
  end

  assign tx  = x >>> iter;
  assign ty  = y >>> iter;
  assign tab = atan_q12(ATAN_IDX_W'(iter));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
      end else if (busy && iter == IW'(N - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x       <= W'(px) <<< N;
      y       <= W'(py) <<< N;
      z       <= pz;
      iter    <= '0;
      is_zero <= (dx == '0) && (dy == '0);
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ty;
        y <= y - tx;
        z <= z + tab;
      end else begin
        x <= x - ty;
        y <= y + tx;
        z <= z - tab;
      end
      iter <= iter + 1'b1;
    end
  end

  assign angle = is_zero ? '0 : z;

endmodule

// ===== design/ats_datapath.sv =====
module ats_datapath #(
  parameter int CW = 16,
  parameter int N  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ats_pkg::THRESH_W-1:0]       cfg_data,
  input  logic signed [CW-1:0]               point_x,
  input  logic signed [CW-1:0]               point_y,
  input  logic                               last_point,
  input  ats_pkg::cmd_t                      cmd,
  output ats_pkg::stat_t                     stat,
  output logic                               seg_valid,
  input  logic                               seg_ready,
  output logic signed [CW-1:0]               seg_start_x,
  output logic signed [CW-1:0]               seg_start_y,
  output logic signed [CW-1:0]               seg_end_x,
  output logic signed [CW-1:0]               seg_end_y,
  output logic                               final_segment
);
  import ats_pkg::*;

  logic signed [CW-1:0]      cur_x, cur_y, start_x, start_y, prev_x, prev_y;
  logic                      cur_last;
  logic signed [ANGLE_W-1:0] ref_angle, angle;
  logic [THRESH_W-1:0]       angle_threshold;
  logic signed [CW:0]        dx, dy;
  logic                      angle_done;
  logic signed [ANGLE_W:0]   diff;
  logic [ANGLE_W:0]          mag;
  logic                      out_free;

  assign dx = (CW+1)'(cur_x) - (CW+1)'(start_x);
  assign dy = (CW+1)'(cur_y) - (CW+1)'(start_y);

  ats_cordic #(.CW(CW), .N(N)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .go    (cmd.angle_go),
    .dx    (dx),
    .dy    (dy),
    .done  (angle_done),
    .angle (angle)
  );

  // Deviation from the reference angle, compared without wrap-around.
  assign diff = (ANGLE_W+1)'(angle) - (ANGLE_W+1)'(ref_angle);
  assign mag  = diff[ANGLE_W] ? (ANGLE_W+1)'(-diff) : (ANGLE_W+1)'(diff);

  assign out_free = !seg_valid || seg_ready;

  assign stat.last       = cur_last;
  assign stat.angle_done = angle_done;
  assign stat.brk        = mag > {2'b00, angle_threshold};
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      angle_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_x    <= point_x;
      cur_y    <= point_y;
      cur_last <= last_point;
    end
    if (cmd.load_first) begin
      start_x <= cur_x;
      start_y <= cur_y;
      prev_x  <= cur_x;
      prev_y  <= cur_y;
    end
    if (cmd.set_prev) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (cmd.set_ref) begin
      ref_angle <= angle;
    end
    if (cmd.emit_break) begin
      start_x <= prev_x;
      start_y <= prev_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (cmd.emit_break || cmd.emit_final) begin
      seg_valid <= 1'b1;
    end else if (seg_ready) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_break) begin
      seg_start_x   <= start_x;
      seg_start_y   <= start_y;
      seg_end_x     <= prev_x;
      seg_end_y     <= prev_y;
      final_segment <= 1'b0;
    end else if (cmd.emit_final) begin
      seg_start_x   <= start_x;
      seg_start_y   <= start_y;
      seg_end_x     <= cur_x;
      seg_end_y     <= cur_y;
      final_segment <= 1'b1;
    end
  end

endmodule

// ===== design/ats_ctrl.sv =====
module ats_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           point_valid,
  output logic           point_ready,
  input  ats_pkg::stat_t stat,
  output ats_pkg::cmd_t  cmd
);
  import ats_pkg::*;

  state_t     state, state_next;
  logic [1:0] seen, seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seen  <= 2'd0;
    end else begin
      state <= state_next;
      seen  <= seen_next;
    end
  end

  always_comb begin
    state_next = state;
    seen_next  = seen;
    unique case (state)
      S_IDLE: begin
        if (point_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (seen == 2'd0) begin
          seen_next  = 2'd1;
          state_next = stat.last ? S_EMIT_FINAL : S_IDLE;
        end else begin
          state_next = S_ANGLE;
        end
      end
      S_ANGLE: begin
        if (stat.angle_done) begin
          if (seen == 2'd1) begin
            seen_next  = 2'd2;
            state_next = stat.last ? S_EMIT_FINAL : S_IDLE;
          end else begin
            state_next = S_COMPARE;
          end
        end
      end
      S_COMPARE: begin
        if (stat.brk) state_next = S_EMIT_BREAK;
        else          state_next = stat.last ? S_EMIT_FINAL : S_IDLE;
      end
      S_EMIT_BREAK: begin
        if (stat.out_free) state_next = S_RESTART;
      end
      S_RESTART: begin
        state_next = S_REANGLE;
      end
      S_REANGLE: begin
        if (stat.angle_done) state_next = stat.last ? S_EMIT_FINAL : S_IDLE;
      end
      S_EMIT_FINAL: begin
        if (stat.out_free) begin
          seen_next  = 2'd0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    point_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        point_ready = 1'b1;
        cmd.capture = point_valid;
      end
      S_DISPATCH: begin
        if (seen == 2'd0) cmd.load_first = 1'b1;
        else              cmd.angle_go   = 1'b1;
      end
      S_ANGLE: begin
        if (stat.angle_done && seen == 2'd1) begin
          cmd.set_ref  = 1'b1;
          cmd.set_prev = 1'b1;
        end
      end
      S_COMPARE: begin
        cmd.set_prev = !stat.brk;
      end
      S_EMIT_BREAK: begin
        cmd.emit_break = stat.out_free;
      end
      S_RESTART: begin
        cmd.angle_go = 1'b1;
      end
      S_REANGLE: begin
        if (stat.angle_done) begin
          cmd.set_ref  = 1'b1;
          cmd.set_prev = 1'b1;
        end
      end
      S_EMIT_FINAL: begin
        cmd.emit_final = stat.out_free;
      end
      default: ;
    endcase
  end

  a_seen_range: assert property (@(posedge clk) disable iff (rst) seen != 2'd3)
    else $error("point count out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_break || cmd.emit_final) |-> stat.out_free)
    else $error("segment loaded while output register is occupied");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    stat.angle_done |-> (state == S_ANGLE || state == S_REANGLE))
    else $error("angle result arrived outside an angle wait");

  a_compare_seen: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPARE) |-> (seen == 2'd2))
    else $error("comparison without a reference angle");

endmodule

// ===== design/angle_threshold_line_segmenter_top.sv =====
// Angle-threshold line segmenter.
// Points enter on the point channel (point_x, point_y, last_point) and
// segments leave on the segment channel (start, end, final_segment); a
// transaction completes when valid and ready are both high at a clock edge.
// The angle threshold resets to 205 (0.05 rad in Q3.12); the user writes it
// through cfg_we/cfg_data while the block is idle, which it does not enforce.
// One point is processed at a time. The first point of a stream only loads
// the segment start; the second and any later point wait for the iterative
// CORDIC arctangent unit, which performs one rotation per cycle. The second
// point sets the reference angle, and each later point is compared to it.
// A point that breaks the segment runs the CORDIC a second time, and a final
// point then loads the closing segment. A segment is presented on the output
// from the clock edge that loads it into the output register.
// The output register decouples the two sides: a new point is accepted while
// a segment waits to be taken, but if the receiver stalls, the block holds in
// its emit state until the register frees up.
// Synchronous reset clears the point count, so the next point opens a
// stream, and drops any pending output segment.
module angle_threshold_line_segmenter_top #(
  parameter int COORD_WIDTH      = 16,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ats_pkg::THRESH_W-1:0]  cfg_data,
  ats_point_if.sink                     point,
  ats_seg_if.source                     segment
);
  import ats_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ats_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point.valid),
    .point_ready (point.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  ats_datapath #(.CW(COORD_WIDTH), .N(ANGLE_ITERATIONS)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .point_x       (point.point_x),
    .point_y       (point.point_y),
    .last_point    (point.last_point),
    .cmd           (cmd),
    .stat          (stat),
    .seg_valid     (segment.valid),
    .seg_ready     (segment.ready),
    .seg_start_x   (segment.seg_start_x),
    .seg_start_y   (segment.seg_start_y),
    .seg_end_x     (segment.seg_end_x),
    .seg_end_y     (segment.seg_end_y),
    .final_segment (segment.final_segment)
  );

endmodule

// ===== sim/angle_threshold_line_segmenter_top_tb.sv =====
`timescale 1ns / 100ps

module angle_threshold_line_segmenter_top_tb;

  localparam int CW          = 16;
  localparam int ITER        = 16;
  localparam int HALF_PI_Q12 = 6434;
  // Worst case per point: two arctangent passes, the compare and the final load.
  localparam int BUSY_CYCLES = 2 * ITER + 32;
  localparam int PHASE_ITEMS = 140;
  localparam int LIMIT_NS    = 2_000_000;

  localparam int ATAN_Q12 [24] = '{
    3217, 1899, 1003, 509, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } point_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic                 fin;
  } seg_t;

  typedef struct packed {
    point_t pt;
    logic   typed;
    seg_t   want;
  } plan_row_t;

  localparam seg_t NO_SEG = '0;

  // Rows with a typed segment are single-point streams and a two-point stream.
  localparam plan_row_t DIRECTED_PLAN [24] = '{
    '{'{16'sh8000, 16'sh7FFF, 1'b1}, 1'b1,
      '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1}},
    '{'{16'sh7FFF, 16'sh8000, 1'b1}, 1'b1,
      '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1}},
    '{'{16'sd0, 16'sd0, 1'b1}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{'{16'sd5, 16'sd5, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sd7, 16'sd9, 1'b1}, 1'b1, '{16'sd5, 16'sd5, 16'sd7, 16'sd9, 1'b1}},
    '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sd100, 16'sd0, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sd200, 16'sd0, 1'b1}, 1'b0, NO_SEG},
    '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sd100, 16'sd0, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sd100, 16'sd100, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sd100, 16'sd200, 1'b1}, 1'b0, NO_SEG},
    '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sd10, 16'sd0, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sd10, -16'sd10, 1'b1}, 1'b0, NO_SEG},
    '{'{16'sh8000, 16'sh8000, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sh7FFF, 16'sh7FFF, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sh7FFF, 16'sh8000, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sh8000, 16'sh7FFF, 1'b0}, 1'b0, NO_SEG},
    '{'{16'sh8000, 16'sh8000, 1'b1}, 1'b0, NO_SEG},
    '{'{16'sd0, 16'sd0, 1'b0}, 1'b0, NO_SEG},
    '{'{-16'sd10, -16'sd1, 1'b0}, 1'b0, NO_SEG},
    '{'{-16'sd20, -16'sd3, 1'b1}, 1'b0, NO_SEG}
  };

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [ats_pkg::THRESH_W-1:0] cfg_data;

  ats_point_if #(.CW(CW)) point_ch ();
  ats_seg_if   #(.CW(CW)) seg_ch ();

  angle_threshold_line_segmenter_top #(
    .COORD_WIDTH      (CW),
    .ANGLE_ITERATIONS (ITER)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .point    (point_ch),
    .segment  (seg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the segmenter state.
  logic signed [CW-1:0]         origin_x = '0;
  logic signed [CW-1:0]         origin_y = '0;
  logic signed [CW-1:0]         prior_x = '0;
  logic signed [CW-1:0]         prior_y = '0;
  int                           heading_ref = 0;
  int                           stream_pts = 0;
  logic [ats_pkg::THRESH_W-1:0] thresh_q12 = ats_pkg::THRESH_RESET;

  seg_t pending_segs[$];
  int   err_cnt = 0;
  int   pts_sent = 0;
  int   segs_seen = 0;
  int   breaks_seen = 0;
  int   settings_used = 0;

  function automatic int arctan_q12(input longint dy, input longint dx);
    longint vx, vy, tx, ty;
    int     z;
    if (dx == 0 && dy == 0) return 0;
    if (dx < 0 && dy >= 0) begin
      vx = dy; vy = -dx; z = HALF_PI_Q12;
    end else if (dx < 0) begin
      vx = -dy; vy = dx; z = -HALF_PI_Q12;
    end else begin
      vx = dx; vy = dy; z = 0;
    end
    vx = vx <<< ITER;
    vy = vy <<< ITER;
    for (int i = 0; i < ITER; i++) begin
      tx = vx >>> i;
      ty = vy >>> i;
      if (vy > 0) begin
        vx += ty; vy -= tx; z += ATAN_Q12[i];
      end else begin
        vx -= ty; vy += tx; z -= ATAN_Q12[i];
      end
    end
    return z;
  endfunction

  function automatic int advance_segmenter(input point_t p, output seg_t segs [2]);
    int n;
    int dev;
    n = 0;
    segs[0] = NO_SEG;
    segs[1] = NO_SEG;
    if (stream_pts == 0) begin
      origin_x = p.x; origin_y = p.y;
      stream_pts = 1;
    end else if (stream_pts == 1) begin
      heading_ref = arctan_q12(longint'(p.y) - longint'(origin_y),
                               longint'(p.x) - longint'(origin_x));
      stream_pts = 2;
    end else begin
      dev = arctan_q12(longint'(p.y) - longint'(origin_y),
                       longint'(p.x) - longint'(origin_x)) - heading_ref;
      if (dev < 0) dev = -dev;
      if (dev > int'(thresh_q12)) begin
        segs[n] = '{origin_x, origin_y, prior_x, prior_y, 1'b0};
        n++;
        origin_x = prior_x; origin_y = prior_y;
        heading_ref = arctan_q12(longint'(p.y) - longint'(origin_y),
                                 longint'(p.x) - longint'(origin_x));
      end
    end
    prior_x = p.x; prior_y = p.y;
    if (p.last) begin
      segs[n] = '{origin_x, origin_y, p.x, p.y, 1'b1};
      n++;
      stream_pts = 0;
    end
    return n;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_segment();
    seg_t got, want;
    got = '{seg_ch.seg_start_x, seg_ch.seg_start_y, seg_ch.seg_end_x, seg_ch.seg_end_y,
            seg_ch.final_segment};
    segs_seen++;
    if (!got.fin) breaks_seen++;
    if (pending_segs.size() == 0) begin
      report_mismatch("segment with nothing pending, start_x", longint'(got.sx), 0);
    end else begin
      want = pending_segs.pop_front();
      if (got.sx !== want.sx) report_mismatch("seg_start_x", longint'(got.sx), longint'(want.sx));
      if (got.sy !== want.sy) report_mismatch("seg_start_y", longint'(got.sy), longint'(want.sy));
      if (got.ex !== want.ex) report_mismatch("seg_end_x", longint'(got.ex), longint'(want.ex));
      if (got.ey !== want.ey) report_mismatch("seg_end_y", longint'(got.ey), longint'(want.ey));
      if (got.fin !== want.fin) report_mismatch("final_segment", got.fin, want.fin);
    end
  endtask

  // Returns at the edge where the point transaction completes.
  task automatic put_point(input point_t p, input int gap, input bit typed, input seg_t want);
    seg_t segs [2];
    int   n;
    if (gap > 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_ch.valid      <= 1'b1;
    point_ch.point_x    <= p.x;
    point_ch.point_y    <= p.y;
    point_ch.last_point <= p.last;
    do @(posedge clk); while (!point_ch.ready);
    n = advance_segmenter(p, segs);
    if (typed) pending_segs = {pending_segs, want};
    else for (int k = 0; k < n; k++) pending_segs = {pending_segs, segs[k]};
    pts_sent++;
  endtask

  task automatic drain_segments();
    point_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_segs.size() != 0);
  endtask

  // A stream is either a noisy walk with occasional turns or random points.
  task automatic send_stream(input int len);
    point_t p;
    int     cx, cy, sx, sy, jit;
    bit     scatter, quiet;
    scatter = ($urandom_range(0, 4) == 0);
    quiet   = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) == 0) begin
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      cx = int'($urandom_range(0, 40000)) - 20000;
      cy = int'($urandom_range(0, 40000)) - 20000;
    end
    sx = int'($urandom_range(0, 6000)) - 3000;
    sy = int'($urandom_range(0, 6000)) - 3000;
    for (int k = 0; k < len; k++) begin
      if (scatter) begin
        p.x = CW'($urandom);
        p.y = CW'($urandom);
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          sx = int'($urandom_range(0, 6000)) - 3000;
          sy = int'($urandom_range(0, 6000)) - 3000;
          if ($urandom_range(0, 9) == 0) begin
            sx = 0; sy = 0;
          end
        end
        jit = ($urandom_range(0, 9) == 0) ? 200 : 3;
        cx = cx + sx + int'($urandom_range(0, 2 * jit)) - jit;
        cy = cy + sy + int'($urandom_range(0, 2 * jit)) - jit;
        if (cx > 32767) cx = 32767;
        else if (cx < -32768) cx = -32768;
        if (cy > 32767) cy = 32767;
        else if (cy < -32768) cy = -32768;
        p.x = CW'(cx);
        p.y = CW'(cy);
      end
      p.last = (k == len - 1);
      put_point(p, quiet ? 0 : pick_gap(), 1'b0, NO_SEG);
    end
  endtask

  // Segment side: checks every transaction and stalls at random.
  initial begin : seg_sink
    int hold_left;
    hold_left = 0;
    seg_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && seg_ch.valid && seg_ch.ready) check_segment();
      if (hold_left > 0) begin
        hold_left--;
      end else if (!seg_ch.ready || $urandom_range(0, 3) == 0) begin
        seg_ch.ready <= 1'b1;
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(0, 6);
      end else begin
        seg_ch.ready <= 1'b0;
        hold_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    logic [ats_pkg::THRESH_W-1:0] thr_plan [7];
    int target;
    int len;
    int r;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_data            <= '0;
    point_ch.valid      <= 1'b0;
    point_ch.point_x    <= '0;
    point_ch.point_y    <= '0;
    point_ch.last_point <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_PLAN[i])
      put_point(DIRECTED_PLAN[i].pt, pick_gap(), DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);

    thr_plan = '{15'd0, 15'd25736, 15'h7FFF, 15'($urandom_range(0, 600)), 15'($urandom),
                 ats_pkg::THRESH_RESET, 15'($urandom_range(100, 2000))};
    target = pts_sent;
    foreach (thr_plan[ph]) begin
      // The threshold may only change once the block has gone quiet.
      drain_segments();
      repeat (BUSY_CYCLES) @(posedge clk);
      cfg_we   <= 1'b1;
      cfg_data <= thr_plan[ph];
      @(posedge clk);
      cfg_we     <= 1'b0;
      thresh_q12 = thr_plan[ph];
      settings_used++;
      target += PHASE_ITEMS;
      while (pts_sent < target) begin
        if ($urandom_range(0, 29) == 0) drain_segments();
        r = $urandom_range(0, 9);
        len = (r == 0) ? 1 : (r == 1) ? 2 : $urandom_range(3, 16);
        send_stream(len);
      end
    end

    drain_segments();
    repeat (2 * BUSY_CYCLES) @(posedge clk);
    if (pending_segs.size() != 0)
      report_mismatch("segments still pending", pending_segs.size(), 0);
    $display("Summary: %0d points sent, %0d segments checked (%0d break segments)",
             pts_sent, segs_seen, breaks_seen);
    $display("Summary: %0d threshold settings after the reset value", settings_used);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("[%0t] timeout, %0d segments still pending", $time, pending_segs.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
